// ===== rtl/sdp_pkg.sv =====
// shared constants of the segment distance and proximity unit
// no dependencies; imported by the top level and by sdp_div_pipe
package sdp_pkg;

	// width of the distance and radius words, Q17.8 unsigned
	localparam int DIST_BITS = 25;
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

endpackage

// ===== rtl/sdp_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per register stage
// depends on sdp_pkg; quotient must be known to fit in Q_W bits
module sdp_div_pipe
	import sdp_pkg::*;
#(
	parameter int NUM_W = 86,
	parameter int DEN_W = 34,
	parameter int Q_W   = 52
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             out_valid,
	output logic [Q_W-1:0]   quot
);

	logic [DEN_W-1:0] rem_s [Q_W+1];
	logic [Q_W-1:0]   nq_s  [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic             vld_s [Q_W+1];

	// upper numerator bits are below the divisor by construction
	assign rem_s[0] = num[NUM_W-1:Q_W];
	assign nq_s[0]  = num[Q_W-1:0];
	assign den_s[0] = den;
	assign vld_s[0] = in_valid;

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[i], nq_s[i][Q_W-1]};
			diff  = trial - {1'b0, den_s[i]};
			ge    = trial >= {1'b0, den_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nq_s[i+1]  <= {nq_s[i][Q_W-2:0], ge};
			den_s[i+1] <= den_s[i];
		end
	end

	assign out_valid = vld_s[Q_W];
	assign quot      = nq_s[Q_W];

	// remainder at the last stage is below the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Q_W] |-> rem_s[Q_W] < den_s[Q_W])
		else $error("divider remainder not below divisor");

endmodule

// ===== rtl/segment_distance_and_proximity_unit.sv =====
// top level of the segment distance and proximity unit
// depends on sdp_pkg and sdp_div_pipe
//
// usage
//   input word: two segments a (ax0,ay0)-(ax1,ay1) and b (bx0,by0)-(bx1,by1),
//   taken at a rising edge with start high and busy low; busy is never raised,
//   so one word can enter every cycle
//   result word: distance (Q17.8, rounded down, zero when crossing), crossing
//   and near, shown for exactly one cycle with done high; the receiver cannot
//   hold results off and none is needed since the pipeline never backs up
//   path: input stages, the one-bit-per-stage divider, the minimum stages, the
//   one-bit-per-stage square root and the output register
//   throughput: one word per cycle
//   config: user writes radius over cfg_valid/cfg_ready (always ready) only while no
//   word is in flight, not enforced; near is distance strictly below radius, or crossing
//   reset: all valid bits and done clear, radius clears to zero
module segment_distance_and_proximity_unit
	import sdp_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] ax0,
	input  logic signed [COORD_BITS-1:0] ay0,
	input  logic signed [COORD_BITS-1:0] ax1,
	input  logic signed [COORD_BITS-1:0] ay1,
	input  logic signed [COORD_BITS-1:0] bx0,
	input  logic signed [COORD_BITS-1:0] by0,
	input  logic signed [COORD_BITS-1:0] bx1,
	input  logic signed [COORD_BITS-1:0] by1,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [DIST_BITS-1:0]         cfg_wdata,
	output logic                         done,
	output logic [DIST_BITS-1:0]         distance,
	output logic                         crossing,
	output logic                         near
);

	// widths: coordinate difference, squares and lengths, signed cross product
	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * COORD_BITS + 2;
	localparam int CW  = 2 * COORD_BITS + 3;
	// squared distance in fixed point, its root, and the divider numerator
	localparam int QW  = 2 * COORD_BITS + 2 + 2 * FRAC_BITS;
	localparam int RW  = COORD_BITS + 1 + FRAC_BITS;
	localparam int NW  = 2 * PW + 2 * FRAC_BITS;
	localparam int MW  = (RW > DIST_BITS) ? RW : DIST_BITS;
	localparam int LAT = 7 + QW + RW;

	logic accept;
	logic cfg_wr;
	logic [DIST_BITS-1:0] radius_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_wr) begin
			radius_q <= cfg_wdata;
		end
	end

	// stage 1: per candidate (point against segment) difference vectors
	// candidate 0: b0 vs a, 1: b1 vs a, 2: a0 vs b, 3: a1 vs b
	// the cross products of these double as the four orientation tests
	logic signed [DW-1:0] px [4], py [4], s0x [4], s0y [4], s1x [4], s1y [4];
	logic box_c [4];

	always_comb begin
		px[0] = DW'(bx0); py[0] = DW'(by0);
		px[1] = DW'(bx1); py[1] = DW'(by1);
		px[2] = DW'(ax0); py[2] = DW'(ay0);
		px[3] = DW'(ax1); py[3] = DW'(ay1);
		for (int k = 0; k < 4; k++) begin
			s0x[k] = (k < 2) ? DW'(ax0) : DW'(bx0);
			s0y[k] = (k < 2) ? DW'(ay0) : DW'(by0);
			s1x[k] = (k < 2) ? DW'(ax1) : DW'(bx1);
			s1y[k] = (k < 2) ? DW'(ay1) : DW'(by1);
			// point inside the bounding box of the other segment
			box_c[k] = ((px[k] >= s0x[k]) || (px[k] >= s1x[k]))
				&& ((px[k] <= s0x[k]) || (px[k] <= s1x[k]))
				&& ((py[k] >= s0y[k]) || (py[k] >= s1y[k]))
				&& ((py[k] <= s0y[k]) || (py[k] <= s1y[k]));
		end
	end

	logic                 v_s1;
	logic signed [DW-1:0] wx_s1 [4], wy_s1 [4], vx_s1 [4], vy_s1 [4];
	logic signed [DW-1:0] dx_s1 [4], dy_s1 [4];
	logic                 box_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			wx_s1[k]  <= px[k] - s0x[k];
			wy_s1[k]  <= py[k] - s0y[k];
			vx_s1[k]  <= px[k] - s1x[k];
			vy_s1[k]  <= py[k] - s1y[k];
			dx_s1[k]  <= s1x[k] - s0x[k];
			dy_s1[k]  <= s1y[k] - s0y[k];
			box_s1[k] <= box_c[k];
		end
	end

	// stage 2: products - cross, projection, lengths squared
	logic                 v_s2;
	logic signed [CW-1:0] c_s2 [4], t_s2 [4];
	logic [PW-1:0]        len2_s2 [4], epw_s2 [4], epv_s2 [4];
	logic                 box_s2 [4];
	logic signed [CW-1:0] len2_c [4], epw_c [4], epv_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			len2_c[k] = CW'(dx_s1[k]) * CW'(dx_s1[k]) + CW'(dy_s1[k]) * CW'(dy_s1[k]);
			epw_c[k]  = CW'(wx_s1[k]) * CW'(wx_s1[k]) + CW'(wy_s1[k]) * CW'(wy_s1[k]);
			epv_c[k]  = CW'(vx_s1[k]) * CW'(vx_s1[k]) + CW'(vy_s1[k]) * CW'(vy_s1[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			c_s2[k]    <= CW'(dx_s1[k]) * CW'(wy_s1[k]) - CW'(dy_s1[k]) * CW'(wx_s1[k]);
			t_s2[k]    <= CW'(wx_s1[k]) * CW'(dx_s1[k]) + CW'(wy_s1[k]) * CW'(dy_s1[k]);
			len2_s2[k] <= len2_c[k][PW-1:0];
			epw_s2[k]  <= epw_c[k][PW-1:0];
			epv_s2[k]  <= epv_c[k][PW-1:0];
			box_s2[k]  <= box_s1[k];
		end
	end

	// stage 3: crossing test and choice of endpoint or perpendicular
	logic cpos [4], cneg [4], czero [4];
	logic cross_c;
	logic perp_c [4], ends_c [4];
	logic signed [CW-1:0] cabs_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cneg[k]   = c_s2[k][CW-1];
			czero[k]  = (c_s2[k] == '0);
			cpos[k]   = !cneg[k] && !czero[k];
			cabs_c[k] = cneg[k] ? -c_s2[k] : c_s2[k];
			// foot at or before the start, or a zero-length segment
			ends_c[k] = (len2_s2[k] == '0) || t_s2[k][CW-1] || (t_s2[k] == '0);
			perp_c[k] = !ends_c[k] && (t_s2[k] < $signed(CW'(len2_s2[k])));
		end
		cross_c = (((cpos[0] && cneg[1]) || (cneg[0] && cpos[1]))
				&& ((cpos[2] && cneg[3]) || (cneg[2] && cpos[3])))
			|| (czero[0] && box_s2[0]) || (czero[1] && box_s2[1])
			|| (czero[2] && box_s2[2]) || (czero[3] && box_s2[3]);
	end

	logic          v_s3, cross_s3;
	logic          perp_s3 [4];
	logic [PW-1:0] mag_s3 [4], ep_s3 [4], len2_s3 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cross_s3 <= cross_c;
		for (int k = 0; k < 4; k++) begin
			perp_s3[k] <= perp_c[k];
			mag_s3[k]  <= cabs_c[k][PW-1:0];
			ep_s3[k]   <= ends_c[k] ? epw_s2[k] : epv_s2[k];
			len2_s3[k] <= len2_s2[k];
		end
	end

	// stage 4: divider operands, squared distance times 2^(2*frac) over den
	logic            v_s4, cross_s4;
	logic [NW-1:0]   num_s4 [4];
	logic [PW-1:0]   den_s4 [4];
	logic [2*PW-1:0] sq_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sq_c[k] = (2*PW)'(mag_s3[k]) * (2*PW)'(mag_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cross_s4 <= cross_s3;
		for (int k = 0; k < 4; k++) begin
			num_s4[k] <= perp_s3[k] ? (NW'(sq_c[k]) << (2 * FRAC_BITS))
				: (NW'(ep_s3[k]) << (2 * FRAC_BITS));
			den_s4[k] <= perp_s3[k] ? len2_s3[k] : PW'(1);
		end
	end

	// four dividers in lockstep, crossing flag rides alongside
	logic          dv [4];
	logic [QW-1:0] q [4];
	logic          cross_dl [QW+1];

	for (genvar k = 0; k < 4; k++) begin : g_div
		sdp_div_pipe #(
			.NUM_W (NW),
			.DEN_W (PW),
			.Q_W   (QW)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_s4),
			.num       (num_s4[k]),
			.den       (den_s4[k]),
			.out_valid (dv[k]),
			.quot      (q[k])
		);
	end

	assign cross_dl[0] = cross_s4;
	for (genvar i = 0; i < QW; i++) begin : g_xdl
		always_ff @(posedge clk) begin
			cross_dl[i+1] <= cross_dl[i];
		end
	end

	// stages 5 and 6: minimum of the four squared distances
	logic          v_s5, v_s6, cross_s5, cross_s6;
	logic [QW-1:0] m01_s5, m23_s5, m_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s5 <= dv[0] && dv[1] && dv[2] && dv[3];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		cross_s5 <= cross_dl[QW];
		m01_s5   <= (q[1] < q[0]) ? q[1] : q[0];
		m23_s5   <= (q[3] < q[2]) ? q[3] : q[2];
		cross_s6 <= cross_s5;
		m_s6     <= (m23_s5 < m01_s5) ? m23_s5 : m01_s5;
	end

	// integer square root, one result bit per stage
	logic [RW:0]   sr_rem  [RW+1];
	logic [RW-1:0] sr_root [RW+1];
	logic [QW-1:0] sr_rest [RW+1];
	logic          sr_v    [RW+1];
	logic          sr_x    [RW+1];

	assign sr_rem[0]  = '0;
	assign sr_root[0] = '0;
	assign sr_rest[0] = m_s6;
	assign sr_v[0]    = v_s6;
	assign sr_x[0]    = cross_s6;

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [RW+1:0] trial, sub, diff;
		logic          ge;

		always_comb begin
			trial = {sr_rem[j][RW-1:0], sr_rest[j][QW-1:QW-2]};
			sub   = {1'b0, sr_root[j][RW-2:0], 2'b01};
			diff  = trial - sub;
			ge    = trial >= sub;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v[j+1] <= 1'b0;
			end else begin
				sr_v[j+1] <= sr_v[j];
			end
		end

		always_ff @(posedge clk) begin
			sr_rem[j+1]  <= ge ? diff[RW:0] : trial[RW:0];
			sr_root[j+1] <= {sr_root[j][RW-2:0], ge};
			sr_rest[j+1] <= sr_rest[j] << 2;
			sr_x[j+1]    <= sr_x[j];
		end
	end

	// output register: saturate, force zero on crossing, radius compare
	logic [MW-1:0]        root_w;
	logic [DIST_BITS-1:0] dist_c;

	always_comb begin
		root_w = MW'(sr_root[RW]);
		if (sr_x[RW]) begin
			dist_c = '0;
		end else if (root_w > MW'(DIST_MAX)) begin
			dist_c = DIST_MAX;
		end else begin
			dist_c = root_w[DIST_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sr_v[RW];
		end
	end

	always_ff @(posedge clk) begin
		distance <= dist_c;
		crossing <= sr_x[RW];
		near     <= sr_x[RW] || (dist_c < radius_q);
	end

	// a crossing pair always reports zero distance
	a_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && crossing |-> distance == '0)
		else $error("crossing result with nonzero distance");

	// near without crossing only when strictly inside the radius
	a_near_radius: assert property (@(posedge clk) disable iff (!arst_n)
		done && near && !crossing |-> distance < radius_q)
		else $error("near set outside radius");

	// every result comes from a word accepted a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without matching input word");

	// the four dividers stay in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dv[0] == dv[1] && dv[0] == dv[2] && dv[0] == dv[3])
		else $error("divider valid bits out of step");

endmodule
